@@ src/waveform_trace_plotter_defines.svh @@
// Assertion helpers for the trace plotter.
// Both expect clk_i and rst_ni in the scope where they are used.
`ifndef WAVEFORM_TRACE_PLOTTER_DEFINES_SVH
`define WAVEFORM_TRACE_PLOTTER_DEFINES_SVH

// Same-cycle implication
`define WTP_ASSERT_IMP(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication
`define WTP_ASSERT_NXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ src/wtp_pkg.sv @@
package wtp_pkg;

  // Configuration port
  localparam int CFG_AW = 3;
  localparam int CFG_DW = 32;

  // Register select codes (paddr bit 2)
  localparam logic REG_SCALE = 1'b0;
  localparam logic REG_TRACE = 1'b1;

  localparam int SCALE_W = 5;
  localparam logic [SCALE_W-1:0] SCALE_RESET = 5'd2;
  localparam logic TRACE_RESET = 1'b1;

  // Sequencer states
  typedef enum logic [3:0] {
    ST_LOAD,
    ST_SETUP,
    ST_SCAN,
    ST_DRAIN,
    ST_SCALE,
    ST_FETCH,
    ST_VAL,
    ST_DIV,
    ST_WAIT,
    ST_EMIT
  } state_e;

  // Divider status
  typedef struct packed {
    logic busy;
    logic done;
  } div_stat_t;

endpackage

@@ src/wtp_if.sv @@
// Sample input channel
interface wtp_in_if #(
  parameter int SAMPLE_BITS = 16
) ();
  logic                          valid;
  logic                          ready;
  logic signed [SAMPLE_BITS-1:0] sample;
  logic                          last_sample;

  modport source (output valid, sample, last_sample, input ready);
  modport sink (input valid, sample, last_sample, output ready);
endinterface

// Pixel output channel
interface wtp_out_if #(
  parameter int COL_W = 6,
  parameter int ROW_W = 5
) ();
  logic             valid;
  logic             ready;
  logic [COL_W-1:0] column;
  logic [ROW_W-1:0] row;
  logic             row_clipped;
  logic             last_pixel;

  modport source (output valid, column, row, row_clipped, last_pixel, input ready);
  modport sink (input valid, column, row, row_clipped, last_pixel, output ready);
endinterface

@@ src/wtp_ram.sv @@
module wtp_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 128
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // One write port, one registered read port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

@@ src/wtp_div.sv @@
module wtp_div #(
  parameter int DVD_W = 23,
  parameter int DVS_W = 22
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                start_i,
  input  logic [DVD_W-1:0]    dividend_i,
  input  logic [DVS_W-1:0]    divisor_i,
  output logic [DVD_W-1:0]    quotient_o,
  output wtp_pkg::div_stat_t  stat_o
);

  localparam int CW = $clog2(DVD_W + 1);

  logic [DVD_W-1:0] q_q;
  logic [DVS_W:0]   r_q;
  logic [DVS_W-1:0] dvs_q;
  logic [CW-1:0]    cnt_q;
  logic             busy_q;
  logic             done_q;

  logic [DVS_W:0]   r_shift;
  logic             ge;

  // Restoring step: one quotient bit per cycle
  always_comb begin
    r_shift = {r_q[DVS_W-1:0], q_q[DVD_W-1]};
    ge      = (r_shift >= {1'b0, dvs_q});
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= CW'(DVD_W);
      end else if (busy_q) begin
        cnt_q <= cnt_q - CW'(1);
        if (cnt_q == CW'(1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  // Datapath
  always_ff @(posedge clk_i) begin
    if (start_i) begin
      q_q   <= dividend_i;
      r_q   <= '0;
      dvs_q <= divisor_i;
    end else if (busy_q) begin
      r_q <= ge ? (r_shift - {1'b0, dvs_q}) : r_shift;
      q_q <= {q_q[DVD_W-2:0], ge};
    end
  end

  assign quotient_o  = q_q;
  assign stat_o.busy = busy_q;
  assign stat_o.done = done_q;

endmodule

@@ src/waveform_trace_plotter.sv @@
// Waveform trace plotter: turns a set of signed samples into one lit pixel per
// shown display column.
// Input channel (in_ch_i): one sample word per cycle while in the load phase;
// the word with last_sample set ends the set and starts processing. Words past
// SAMPLE_DEPTH are dropped, but their mark still ends the set.
// Output channel (out_ch_o): one word per shown column, in column order, with
// last_pixel on the final one. A set of n samples gives min(n, DISPLAY_WIDTH).
// Config: APB port, scale divisor at 0x0, trace_select at 0x4.
// Processing: after the marked sample, the setup, scan (one read per sample),
// drain and scale states go over the store for the range; then each column
// is computed by the bit-serial divider shared by all columns, or the divider
// is skipped when the divisor is zero.
// Input is not ready from the marked sample until the last pixel is registered.
// A stalled receiver holds the current pixel in the output register; the next
// column is computed meanwhile and waits for that register to drain.
// Reset clears the sample count, minimum and output valid, and restores the
// scale divisor to 2 and trace_select to 1. The sample store is not cleared.
`include "waveform_trace_plotter_defines.svh"

module waveform_trace_plotter #(
  parameter int SAMPLE_DEPTH   = 128,
  parameter int DISPLAY_WIDTH  = 64,
  parameter int DISPLAY_HEIGHT = 32,
  parameter int SAMPLE_BITS    = 16
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  wtp_in_if.sink                        in_ch_i,
  wtp_out_if.source                     out_ch_o,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [wtp_pkg::CFG_AW-1:0]    paddr,
  input  logic [wtp_pkg::CFG_DW-1:0]    pwdata,
  output logic [wtp_pkg::CFG_DW-1:0]    prdata,
  output logic                          pready
);

  localparam int SB      = SAMPLE_BITS;
  localparam int VAL_W   = SB + 1;
  localparam int AW      = $clog2(SAMPLE_DEPTH);
  localparam int CNT_W   = $clog2(SAMPLE_DEPTH + 1);
  localparam int COL_W   = $clog2(DISPLAY_WIDTH);
  localparam int ROW_W   = $clog2(DISPLAY_HEIGHT);
  localparam int NUM_W   = $clog2(DISPLAY_WIDTH + 1);
  localparam int HB      = $clog2(DISPLAY_HEIGHT + 1);
  localparam int DVD_W   = VAL_W + HB;
  localparam int DEN_W   = wtp_pkg::SCALE_W + VAL_W;
  localparam int SUM_W   = DVD_W + 1;
  localparam int CALC_W  = CNT_W + NUM_W + 1;
  localparam int ROW_OFS = DISPLAY_HEIGHT / 2 + 1;
  localparam int ROW_MAX = DISPLAY_HEIGHT - 1;

  wtp_pkg::state_e state_q, state_d;

  // Configuration registers
  logic [wtp_pkg::SCALE_W-1:0] sf_q;
  logic                        ts_q;

  // Load phase
  logic [CNT_W-1:0]     count_q;
  logic signed [SB-1:0] min_q;
  logic signed [SB-1:0] min_d;
  logic [CNT_W-1:0]     count_d;
  logic [VAL_W-1:0]     min_ext;
  logic [VAL_W-1:0]     lift_d;
  logic                 in_acc;
  logic                 store_we;

  // Set geometry
  logic [CNT_W-1:0] n_q;
  logic [VAL_W-1:0] lift_q;
  logic             gneg_q;
  logic [CNT_W-1:0] g_q;
  logic [CNT_W-1:0] trim_hi_q;
  logic [NUM_W-1:0] num_q;
  logic [CALC_W-1:0] n_ext;
  logic [CALC_W-1:0] w_ext;
  logic             over;
  logic [CALC_W-1:0] g_calc;
  logic [CALC_W-1:0] gp_calc;

  // Walk over the store
  logic [AW-1:0]    idx_q;
  logic             p_q;
  logic [AW-1:0]    p_idx_q;
  logic [COL_W-1:0] col_q;
  logic [VAL_W-1:0] vmax_q, vmin_q;
  logic [DEN_W-1:0] denom_q;
  logic [VAL_W-1:0] v_q;

  // Shared lift unit
  logic [SB-1:0]    rd_data;
  logic [AW-1:0]    val_idx;
  logic             trimmed;
  logic [VAL_W:0]   lift_sum;
  logic [VAL_W-1:0] val;

  // Divider
  logic               div_start;
  logic [DVD_W-1:0]   quotient;
  wtp_pkg::div_stat_t div_stat;

  // Row computation
  logic [DVD_W-1:0] res;
  logic [SUM_W-1:0] row_sum;
  logic             clip;
  logic             out_load;

  // Output register
  logic             out_valid_q;
  logic [COL_W-1:0] out_col_q;
  logic [ROW_W-1:0] out_row_q;
  logic             out_clip_q;
  logic             out_last_q;

  // ---------------- Configuration port ----------------
  assign pready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sf_q <= wtp_pkg::SCALE_RESET;
      ts_q <= wtp_pkg::TRACE_RESET;
    end else if (psel && penable && pwrite) begin
      unique case (paddr[2])
        wtp_pkg::REG_SCALE: sf_q <= pwdata[wtp_pkg::SCALE_W-1:0];
        wtp_pkg::REG_TRACE: ts_q <= pwdata[0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (paddr[2])
      wtp_pkg::REG_SCALE: prdata = wtp_pkg::CFG_DW'(sf_q);
      wtp_pkg::REG_TRACE: prdata = wtp_pkg::CFG_DW'(ts_q);
      default:            prdata = '0;
    endcase
  end

  // ---------------- Sample load ----------------
  assign in_acc   = in_ch_i.valid && in_ch_i.ready;
  assign store_we = in_acc && (count_q < CNT_W'(SAMPLE_DEPTH));

  // Running minimum and its magnitude
  always_comb begin
    min_d   = min_q;
    count_d = count_q;
    if (store_we) begin
      count_d = count_q + CNT_W'(1);
      if ((count_q == '0) || (in_ch_i.sample < min_q)) begin
        min_d = in_ch_i.sample;
      end
    end
    min_ext = {min_d[SB-1], min_d};
    lift_d  = min_ext[VAL_W-1] ? (~min_ext + VAL_W'(1)) : min_ext;
  end

  wtp_ram #(
    .WIDTH (SB),
    .DEPTH (SAMPLE_DEPTH)
  ) u_store (
    .clk_i   (clk_i),
    .we_i    (store_we),
    .waddr_i (count_q[AW-1:0]),
    .wdata_i (in_ch_i.sample),
    .raddr_i (idx_q),
    .rdata_o (rd_data)
  );

  // ---------------- Geometry ----------------
  always_comb begin
    n_ext   = CALC_W'(n_q);
    w_ext   = CALC_W'(DISPLAY_WIDTH);
    over    = (n_ext > w_ext);
    g_calc  = (n_ext - w_ext) >> 1;
    gp_calc = (w_ext - n_ext) >> 1;
  end

  // ---------------- Lift unit ----------------
  always_comb begin
    val_idx  = (state_q == wtp_pkg::ST_VAL) ? idx_q : p_idx_q;
    trimmed  = gneg_q && ((CNT_W'(val_idx) < g_q) || (CNT_W'(val_idx) >= trim_hi_q));
    lift_sum = {{2{rd_data[SB-1]}}, rd_data} + {1'b0, lift_q};
    val      = trimmed ? lift_q : lift_sum[VAL_W-1:0];
  end

  // ---------------- Row ----------------
  always_comb begin
    res     = (denom_q == '0) ? DVD_W'(v_q) : quotient;
    row_sum = SUM_W'(res) + (ts_q ? SUM_W'(0) : SUM_W'(ROW_OFS));
    clip    = (row_sum > SUM_W'(ROW_MAX));
  end

  // ---------------- Sequencer ----------------
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= wtp_pkg::ST_LOAD;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d   = state_q;
    div_start = 1'b0;
    out_load  = 1'b0;
    unique case (state_q)
      wtp_pkg::ST_LOAD: begin
        if (in_acc && in_ch_i.last_sample) begin
          state_d = wtp_pkg::ST_SETUP;
        end
      end
      wtp_pkg::ST_SETUP: state_d = wtp_pkg::ST_SCAN;
      wtp_pkg::ST_SCAN: begin
        if (CNT_W'(idx_q) == (n_q - CNT_W'(1))) begin
          state_d = wtp_pkg::ST_DRAIN;
        end
      end
      wtp_pkg::ST_DRAIN: state_d = wtp_pkg::ST_SCALE;
      wtp_pkg::ST_SCALE: state_d = wtp_pkg::ST_FETCH;
      wtp_pkg::ST_FETCH: state_d = wtp_pkg::ST_VAL;
      wtp_pkg::ST_VAL:   state_d = wtp_pkg::ST_DIV;
      wtp_pkg::ST_DIV: begin
        if (denom_q == '0) begin
          state_d = wtp_pkg::ST_EMIT;
        end else begin
          div_start = 1'b1;
          state_d   = wtp_pkg::ST_WAIT;
        end
      end
      wtp_pkg::ST_WAIT: begin
        if (div_stat.done) begin
          state_d = wtp_pkg::ST_EMIT;
        end
      end
      wtp_pkg::ST_EMIT: begin
        if (!out_valid_q || out_ch_o.ready) begin
          out_load = 1'b1;
          state_d  = (num_q == NUM_W'(1)) ? wtp_pkg::ST_LOAD : wtp_pkg::ST_FETCH;
        end
      end
      default: state_d = wtp_pkg::ST_LOAD;
    endcase
  end

  assign in_ch_i.ready = (state_q == wtp_pkg::ST_LOAD);

  // Control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q     <= '0;
      min_q       <= '0;
      p_q         <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      p_q <= (state_q == wtp_pkg::ST_SCAN);
      if (in_acc && in_ch_i.last_sample) begin
        count_q <= '0;
        min_q   <= '0;
      end else begin
        count_q <= count_d;
        min_q   <= min_d;
      end
      if (out_load) begin
        out_valid_q <= 1'b1;
      end else if (out_ch_o.ready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // Datapath registers
  always_ff @(posedge clk_i) begin
    p_idx_q <= idx_q;

    if (in_acc && in_ch_i.last_sample) begin
      n_q    <= count_d;
      lift_q <= lift_d;
    end

    // Range of the lifted set
    if (p_q) begin
      if ((p_idx_q == '0) || (val > vmax_q)) begin
        vmax_q <= val;
      end
      if ((p_idx_q == '0) || (val < vmin_q)) begin
        vmin_q <= val;
      end
    end

    case (state_q)
      wtp_pkg::ST_SETUP: begin
        gneg_q    <= over;
        g_q       <= over ? CNT_W'(g_calc) : '0;
        trim_hi_q <= n_q - CNT_W'(g_calc);
        col_q     <= over ? '0 : COL_W'(gp_calc);
        num_q     <= over ? NUM_W'(DISPLAY_WIDTH) : NUM_W'(n_q);
        idx_q     <= '0;
      end
      wtp_pkg::ST_SCAN: idx_q <= idx_q + AW'(1);
      wtp_pkg::ST_SCALE: begin
        denom_q <= DEN_W'(sf_q) * DEN_W'(vmax_q - vmin_q);
        idx_q   <= AW'(g_q);
      end
      wtp_pkg::ST_VAL: v_q <= val;
      wtp_pkg::ST_EMIT: begin
        if (out_load) begin
          num_q <= num_q - NUM_W'(1);
          col_q <= col_q + COL_W'(1);
          idx_q <= idx_q + AW'(1);
        end
      end
      default: ;
    endcase

    if (out_load) begin
      out_col_q  <= col_q;
      out_row_q  <= clip ? ROW_W'(ROW_MAX) : row_sum[ROW_W-1:0];
      out_clip_q <= clip;
      out_last_q <= (num_q == NUM_W'(1));
    end
  end

  wtp_div #(
    .DVD_W (DVD_W),
    .DVS_W (DEN_W)
  ) u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i (DVD_W'(v_q) * DVD_W'(DISPLAY_HEIGHT)),
    .divisor_i  (denom_q),
    .quotient_o (quotient),
    .stat_o     (div_stat)
  );

  assign out_ch_o.valid       = out_valid_q;
  assign out_ch_o.column      = out_col_q;
  assign out_ch_o.row         = out_row_q;
  assign out_ch_o.row_clipped = out_clip_q;
  assign out_ch_o.last_pixel  = out_last_q;

  // ---------------- Assertions ----------------
  `WTP_ASSERT_IMP(a_fetch_in_set, state_q == wtp_pkg::ST_FETCH, CNT_W'(idx_q) < n_q, "fetch past end of set")
  `WTP_ASSERT_IMP(a_clip_saturates, out_valid_q && out_clip_q, out_row_q == ROW_W'(ROW_MAX), "clipped row not saturated")
  `WTP_ASSERT_NXT(a_div_runs, div_start, div_stat.busy, "divider did not start")
  `WTP_ASSERT_IMP(a_no_overwrite, out_load && out_valid_q, out_ch_o.ready, "pixel overwritten before taken")

endmodule

@@ tb/tb_top.sv @@
`timescale 1ns / 100ps

module tb_top;

  localparam int DEPTH     = 128;
  localparam int WIDTH     = 64;
  localparam int HEIGHT    = 32;
  localparam int SBITS     = 16;
  localparam int ROW_SHIFT = HEIGHT / 2 + 1;
  localparam int LIMIT     = 400000;
  localparam int SETTLE    = 40;

  typedef struct packed {
    logic signed [SBITS-1:0] value;
    logic                    mark;
  } sample_word_t;

  typedef struct packed {
    logic [5:0] column;
    logic [4:0] row;
    logic       clipped;
    logic       mark;
  } pixel_t;

  logic clk_i = 1'b0;
  logic rst_ni;

  logic                       psel;
  logic                       penable;
  logic                       pwrite;
  logic [wtp_pkg::CFG_AW-1:0] paddr;
  logic [wtp_pkg::CFG_DW-1:0] pwdata;
  logic [wtp_pkg::CFG_DW-1:0] prdata;
  logic                       pready;

  wtp_in_if #(.SAMPLE_BITS(SBITS)) in_ch ();
  wtp_out_if #(.COL_W(6), .ROW_W(5)) out_ch ();

  waveform_trace_plotter dut (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .in_ch_i  (in_ch),
    .out_ch_o (out_ch),
    .psel     (psel),
    .penable  (penable),
    .pwrite   (pwrite),
    .paddr    (paddr),
    .pwdata   (pwdata),
    .prdata   (prdata),
    .pready   (pready)
  );

  // 50 MHz clock
  always begin
    #10 clk_i = 1'b1;
    #10 clk_i = 1'b0;
  end

  sample_word_t sample_feed_q[$];
  pixel_t       pixel_q[$];
  int           send_idle_pct;
  int           recv_idle_pct;
  int           errors;
  int           cycles;
  logic         in_fire;

  // shadow of the block's registers and set state
  logic [4:0]          scale_cfg;
  logic                trace_cfg;
  longint              stored[DEPTH];
  int                  n_stored;
  longint              run_min;

  // Takes one accepted sample; on the marked one, plots the set into pixel_q
  function automatic void plot_sample(logic signed [SBITS-1:0] s, logic mark);
    longint v[DEPTH];
    longint lift, gap, vmax, vmin, denom, r, idx;
    int     n, shown;
    pixel_t px;
    if (n_stored < DEPTH) begin
      if (n_stored == 0 || longint'(s) < run_min) run_min = s;
      stored[n_stored] = s;
      n_stored++;
    end
    if (!mark) return;
    n = n_stored;
    lift = (run_min < 0) ? -run_min : run_min;
    gap = (WIDTH - n) / 2;
    for (int i = 0; i < n; i++) v[i] = stored[i];
    // more samples than columns: trimmed edges go to zero
    if (gap < 0) begin
      for (int i = 0; i < -gap && i < n; i++) v[i] = 0;
      for (longint i = n + gap; i < n; i++)
        if (i >= 0) v[i] = 0;
    end
    vmax = 0;
    vmin = 0;
    for (int i = 0; i < n; i++) begin
      v[i] += lift;
      if (i == 0 || v[i] > vmax) vmax = v[i];
      if (i == 0 || v[i] < vmin) vmin = v[i];
    end
    denom = longint'(scale_cfg) * (vmax - vmin);
    if (denom != 0)
      for (int i = 0; i < n; i++) v[i] = (v[i] * HEIGHT) / denom;
    shown = 0;
    for (int c = 0; c < WIDTH; c++) begin
      idx = c - gap;
      if (idx >= 0 && idx < n) begin
        r = v[idx] + (trace_cfg ? 0 : ROW_SHIFT);
        px.clipped = (r > HEIGHT - 1);
        if (px.clipped) r = HEIGHT - 1;
        px.column = c[5:0];
        px.row = r[4:0];
        px.mark = 1'b0;
        pixel_q.push_back(px);
        shown++;
      end
    end
    if (shown > 0) pixel_q[pixel_q.size()-1].mark = 1'b1;
    n_stored = 0;
    run_min = 0;
  endfunction

  // Sampling at the rising edge: predict on accepted samples, check pixels
  always @(posedge clk_i) begin
    pixel_t want;
    in_fire = rst_ni && in_ch.valid && in_ch.ready;
    if (in_fire) plot_sample(in_ch.sample, in_ch.last_sample);
    if (rst_ni && out_ch.valid && out_ch.ready) begin
      if (pixel_q.size() == 0) begin
        $error("unexpected pixel word: column %0d row %0d", out_ch.column, out_ch.row);
        errors++;
      end else begin
        want = pixel_q.pop_front();
        if (out_ch.column !== want.column) begin
          $error("column: expected %0d, got %0d", want.column, out_ch.column);
          errors++;
        end
        if (out_ch.row !== want.row) begin
          $error("row: expected %0d, got %0d", want.row, out_ch.row);
          errors++;
        end
        if (out_ch.row_clipped !== want.clipped) begin
          $error("row_clipped: expected %0b, got %0b", want.clipped, out_ch.row_clipped);
          errors++;
        end
        if (out_ch.last_pixel !== want.mark) begin
          $error("last_pixel: expected %0b, got %0b", want.mark, out_ch.last_pixel);
          errors++;
        end
      end
    end
  end

  // Sample driver and pixel backpressure, changing on the falling edge
  always @(negedge clk_i) begin
    sample_word_t w;
    logic go;
    if (rst_ni) begin
      if (!in_ch.valid || in_fire) begin
        go = (sample_feed_q.size() != 0) && ($urandom_range(99) >= send_idle_pct);
        if (go) begin
          w = sample_feed_q.pop_front();
          in_ch.sample <= w.value;
          in_ch.last_sample <= w.mark;
        end
        in_ch.valid <= go;
      end
      out_ch.ready <= ($urandom_range(99) >= recv_idle_pct);
    end
  end

  // Watchdog
  always @(posedge clk_i) begin
    cycles++;
    if (cycles > LIMIT) begin
      $display("[waveform_trace_plotter] ERROR");
      $finish;
    end
  end

  task automatic push_word(logic signed [SBITS-1:0] v, logic mark);
    sample_word_t w;
    w.value = v;
    w.mark = mark;
    sample_feed_q.push_back(w);
  endtask

  // Sample shapes: wide random, narrow band, rail values, flat
  function automatic logic signed [SBITS-1:0] pick_sample(int shape,
                                                          logic signed [SBITS-1:0] base);
    if (shape <= 3) return SBITS'($urandom);
    if (shape <= 7) return base + SBITS'($urandom_range(63));
    if (shape == 8) begin
      case ($urandom_range(3))
        0: return 16'sh7fff;
        1: return 16'sh8000;
        default: return SBITS'($urandom);
      endcase
    end
    return base;
  endfunction

  task automatic add_trace(int len, int shape);
    logic signed [SBITS-1:0] base;
    base = SBITS'($urandom);
    for (int i = 0; i < len; i++) push_word(pick_sample(shape, base), i == len - 1);
  endtask

  // Random sets whose lengths add up to the budget
  task automatic add_random_traces(int budget);
    int fed, pick, len;
    fed = 0;
    while (fed < budget) begin
      pick = $urandom_range(99);
      if (pick < 70) len = $urandom_range(1, 12);
      else if (pick < 85) len = $urandom_range(13, 40);
      else if (pick < 95) len = $urandom_range(56, 72);
      else len = $urandom_range(100, DEPTH);
      if (len > budget - fed) len = budget - fed;
      add_trace(len, $urandom_range(9));
      fed += len;
    end
  endtask

  // Wait for all words to go in and all pixels to come out, then settle
  task automatic wait_idle();
    while (sample_feed_q.size() != 0 || in_ch.valid || pixel_q.size() != 0)
      @(negedge clk_i);
    repeat (SETTLE) @(negedge clk_i);
  endtask

  // APB write followed by a read-back of the same register
  task automatic reg_write(logic sel, logic [wtp_pkg::CFG_DW-1:0] data);
    logic [wtp_pkg::CFG_DW-1:0] want;
    @(negedge clk_i);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= {sel, 2'b00};
    pwdata <= data;
    @(negedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    if (sel == wtp_pkg::REG_SCALE) begin
      scale_cfg = data[4:0];
      want = {27'd0, data[4:0]};
    end else begin
      trace_cfg = data[0];
      want = {31'd0, data[0]};
    end
    @(negedge clk_i);
    penable <= 1'b0;
    pwrite <= 1'b0;
    @(negedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    if (prdata !== want) begin
      $error("prdata: expected %0h, got %0h", want, prdata);
      errors++;
    end
    @(negedge clk_i);
    psel <= 1'b0;
    penable <= 1'b0;
  endtask

  initial begin
    errors = 0;
    cycles = 0;
    in_fire = 1'b0;
    n_stored = 0;
    run_min = 0;
    scale_cfg = wtp_pkg::SCALE_RESET;
    trace_cfg = wtp_pkg::TRACE_RESET;
    rst_ni = 1'b0;
    psel = 1'b0;
    penable = 1'b0;
    pwrite = 1'b0;
    paddr = '0;
    pwdata = '0;
    in_ch.valid = 1'b0;
    in_ch.sample = '0;
    in_ch.last_sample = 1'b0;
    out_ch.ready = 1'b0;
    send_idle_pct = 12;
    recv_idle_pct = 76;
    repeat (6) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // reset settings: single-sample sets, rails, flat set, positive minimum
    push_word(16'sh7fff, 1'b1);
    push_word(16'sh8000, 1'b1);
    push_word(16'sh8000, 1'b0);
    push_word(16'sh7fff, 1'b0);
    push_word(16'sh0000, 1'b1);
    push_word(16'sd7, 1'b0);
    push_word(16'sd7, 1'b0);
    push_word(16'sd7, 1'b1);
    push_word(16'sd100, 1'b0);
    push_word(16'sd200, 1'b0);
    push_word(16'sd300, 1'b0);
    push_word(16'sd400, 1'b1);
    wait_idle();

    // zero divisor through the scale register, lower trace offset
    reg_write(wtp_pkg::REG_SCALE, 32'd0);
    reg_write(wtp_pkg::REG_TRACE, 32'd0);
    push_word(-16'sd5, 1'b0);
    push_word(16'sd3, 1'b0);
    push_word(16'sd10, 1'b0);
    push_word(-16'sd1, 1'b1);
    push_word(16'sd1, 1'b1);
    push_word(16'sh7fff, 1'b0);
    push_word(16'sh8000, 1'b1);
    wait_idle();

    // random sets, sender mostly busy, receiver mostly stalled
    reg_write(wtp_pkg::REG_SCALE, 32'd1);
    reg_write(wtp_pkg::REG_TRACE, 32'd1);
    add_random_traces(25);
    wait_idle();

    // roles swapped
    send_idle_pct = 76;
    recv_idle_pct = 12;
    reg_write(wtp_pkg::REG_SCALE, 32'd16);
    reg_write(wtp_pkg::REG_TRACE, 32'd0);
    add_random_traces(25);
    wait_idle();

    // no idling from here on
    send_idle_pct = 0;
    recv_idle_pct = 0;
    reg_write(wtp_pkg::REG_SCALE, 32'hffff_ffff);
    reg_write(wtp_pkg::REG_TRACE, 32'hffff_fffe);
    add_random_traces(15);
    wait_idle();

    // store overflow: the mark lands on a dropped sample
    reg_write(wtp_pkg::REG_SCALE, $urandom_range(1, 16));
    reg_write(wtp_pkg::REG_TRACE, $urandom_range(1));
    add_trace($urandom_range(DEPTH + 1, DEPTH + 5), $urandom_range(9));
    add_random_traces(5);
    wait_idle();

    if (errors == 0) begin
      $display("[waveform_trace_plotter] OK");
    end else begin
      $display("[waveform_trace_plotter] ERROR");
    end
    $finish;
  end

endmodule

@@ waveform_trace_plotter.f @@
+incdir+src
src/wtp_pkg.sv
src/wtp_if.sv
src/wtp_ram.sv
src/wtp_div.sv
src/waveform_trace_plotter.sv
tb/tb_top.sv
